/* hw/rtl/piecewise_linear_interpolator_defines.svh */
// ---------------------------------------------------------------------------
// Piecewise linear interpolator assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define PLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/plin_pkg.sv */
// ---------------------------------------------------------------------------
// Piecewise linear interpolator package
// Command and status codes, shared unit control types.
// ---------------------------------------------------------------------------
`default_nettype none

package plin_pkg;

    localparam int unsigned XW    = 32;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned STS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

endpackage

`default_nettype wire

/* hw/rtl/piecewise_linear_interpolator.sv */
// ---------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table in two RAMs, linear search under a sequencer, and a
// shared iterative unit for the fraction and the scaled output difference.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_cmd, i_point_in, i_point_out
//   out     | output    | o_out_valid / i_out_stall | o_result, o_status
//
// Clear, append and unused commands go from the request to S_DONE, then to the output register.
// Lookup: the end checks (S_CHK0, S_CHKL), a linear scan over up to MAX_POINTS-1
// breakpoints (S_SCAN), then S_SEG, division (S_DIV) and multiplication (S_MUL) in
// the shared unit; the RAM read port is registered and the shared unit is bit-serial.
// Reset clears the point count; table contents are undefined until written.
// o_in_stall is high until the result is registered; a held result adds its stall.
// ---------------------------------------------------------------------------
`default_nettype none
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [31:0] i_point_in,
    input  wire logic signed [31:0] i_point_out,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_result,
    output logic [1:0]              o_status
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned W  = FRAC_BITS + 34;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CHK0 = 8'b0000_0010,
        S_CHKL = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_SEG  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic signed [31:0]    r_q, n_q;
    logic signed [31:0]    r_x0, n_x0;
    logic signed [31:0]    r_y0, n_y0;
    logic signed [31:0]    r_x1, n_x1;
    logic signed [31:0]    r_y1, n_y1;
    logic signed [31:0]    r_res, n_res;
    plin_pkg::t_status     r_sts, n_sts;
    logic                  r_out_valid, n_out_valid;
    logic signed [31:0]    r_out_res;
    plin_pkg::t_status     r_out_sts;

    logic                  in_acc;
    logic                  out_load;
    logic                  ram_we;
    logic [AW-1:0]         rd_addr;
    logic [31:0]           ram_x_rdata;
    logic [31:0]           ram_y_rdata;
    logic signed [31:0]    rd_x;
    logic signed [31:0]    rd_y;
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         last_addr;
    logic signed [32:0]    seg_range;
    logic signed [32:0]    seg_diff;
    logic signed [32:0]    seg_dy;
    plin_pkg::t_alu_ctl    alu_ctl;
    plin_pkg::t_alu_sts    alu_sts;
    logic signed [32:0]    alu_b;
    logic signed [W-1:0]   alu_acc;
    logic                  full_append;
    logic                  full_drop;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign rd_x      = ram_x_rdata;
    assign rd_y      = ram_y_rdata;
    assign cnt_m1    = r_count - CW'(1);
    assign last_addr = cnt_m1[AW-1:0];
    assign seg_range = 33'(r_x1) - 33'(r_x0);
    assign seg_diff  = 33'(r_q) - 33'(r_x0);
    assign seg_dy    = 33'(r_y1) - 33'(r_y0);
    assign alu_b     = (r_state == S_SEG) ? seg_range : seg_dy;

    plin_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_point_in),
        .i_raddr (rd_addr),
        .o_rdata (ram_x_rdata)
    );

    plin_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_point_out),
        .i_raddr (rd_addr),
        .o_rdata (ram_y_rdata)
    );

    plin_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (seg_diff),
        .i_b     (alu_b),
        .o_sts   (alu_sts),
        .o_acc   (alu_acc)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_q         = r_q;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_res       = r_res;
        n_sts       = r_sts;
        ram_we      = 1'b0;
        rd_addr     = '0;
        alu_ctl     = '{start: 1'b0, op: plin_pkg::ALU_DIV};
        out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_sts   = plin_pkg::STS_OK;
                    n_state = S_DONE;
                    case (plin_pkg::t_cmd'(i_cmd))
                        plin_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        plin_pkg::CMD_APPEND: begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_sts = plin_pkg::STS_FULL;
                            end
                        end
                        plin_pkg::CMD_LOOKUP: begin
                            n_q = i_point_in;
                            if (r_count == '0) begin
                                n_sts = plin_pkg::STS_EMPTY;
                            end else begin
                                n_state = S_CHK0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHK0: begin
                n_x0 = rd_x;
                n_y0 = rd_y;
                if (r_q < rd_x) begin
                    n_res   = rd_y;
                    n_state = S_DONE;
                end else begin
                    rd_addr = last_addr;
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                if (r_q > rd_x) begin
                    n_res   = rd_y;
                    n_state = S_DONE;
                end else if (r_count == CW'(1)) begin
                    n_res   = r_y0;
                    n_state = S_DONE;
                end else begin
                    rd_addr = AW'(1);
                    n_idx   = AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_q <= rd_x || r_idx == last_addr) begin
                    n_x1    = rd_x;
                    n_y1    = rd_y;
                    n_state = S_SEG;
                end else begin
                    n_x0    = rd_x;
                    n_y0    = rd_y;
                    n_idx   = r_idx + AW'(1);
                    rd_addr = r_idx + AW'(1);
                end
            end
            S_SEG: begin
                if (seg_range <= 33'sd0 || seg_diff <= 33'sd0) begin
                    n_res   = r_y0;
                    n_state = S_DONE;
                end else begin
                    alu_ctl = '{start: 1'b1, op: plin_pkg::ALU_DIV};
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_sts.done) begin
                    alu_ctl = '{start: 1'b1, op: plin_pkg::ALU_MUL};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (alu_sts.done) begin
                    n_res   = r_y0 + alu_acc[FRAC_BITS +: 32];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_q   <= n_q;
        r_x0  <= n_x0;
        r_y0  <= n_y0;
        r_x1  <= n_x1;
        r_y1  <= n_y1;
        r_res <= n_res;
        r_sts <= n_sts;
        if (out_load) begin
            r_out_res <= r_res;
            r_out_sts <= r_sts;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_res;
    assign o_status    = r_out_sts;

    assign full_append = in_acc && i_cmd == plin_pkg::CMD_APPEND && r_count == CW'(MAX_POINTS);
    assign full_drop   = r_count == CW'(MAX_POINTS) && r_sts == plin_pkg::STS_FULL;

    `PLI_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS), "count over")
    `PLI_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, full_append, full_drop, "full append kept")
    `PLI_ASSERT_IMPL(a_alu_start_idle, i_clk, i_rst_n, alu_ctl.start, !alu_sts.busy, "unit busy")

endmodule

`default_nettype wire

/* hw/rtl/plin_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module plin_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/plin_alu.sv */
// ---------------------------------------------------------------------------
// Shared iterative divide / multiply unit
// One adder runs restoring division for the segment fraction, then
// shift-add multiplication of the output difference by that fraction.
// ---------------------------------------------------------------------------
`default_nettype none
`include "piecewise_linear_interpolator_defines.svh"

module plin_alu #(
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned W = FRAC_BITS + 34
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire plin_pkg::t_alu_ctl  i_ctl,
    input  wire logic signed [32:0]  i_a,
    input  wire logic signed [32:0]  i_b,
    output plin_pkg::t_alu_sts       o_sts,
    output logic signed [W-1:0]      o_acc
);

    localparam int unsigned CNTW = $clog2(FRAC_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_first;
    plin_pkg::t_alu_op     r_op;
    logic signed [32:0]    r_b;
    logic signed [W-1:0]   r_acc;
    logic [FRAC_BITS:0]    r_q;

    logic signed [W-1:0]   sh;
    logic [W-1:0]          b_ext;
    logic [W-1:0]          addend;
    logic [W-1:0]          sum;
    logic                  cin;
    logic                  qbit;
    logic signed [W-1:0]   n_acc;
    logic [FRAC_BITS:0]    n_q;

    assign b_ext = W'(r_b);

    always_comb begin
        sh     = r_first ? r_acc : (r_acc <<< 1);
        cin    = (r_op == plin_pkg::ALU_DIV);
        addend = '0;
        if (r_op == plin_pkg::ALU_DIV) begin
            addend = ~b_ext;
        end else if (r_q[FRAC_BITS]) begin
            addend = b_ext;
        end
        sum  = sh + addend + {{(W-1){1'b0}}, cin};
        qbit = ~sum[W-1];
        if (r_op == plin_pkg::ALU_DIV) begin
            n_acc = qbit ? sum : sh;
            n_q   = {r_q[FRAC_BITS-1:0], qbit};
        end else begin
            n_acc = sum;
            n_q   = {r_q[FRAC_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(FRAC_BITS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_op    <= i_ctl.op;
            r_b     <= i_b;
            r_acc   <= (i_ctl.op == plin_pkg::ALU_DIV) ? W'(i_a) : '0;
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_acc   <= n_acc;
            r_q     <= n_q;
            r_first <= 1'b0;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;

    `PLI_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, r_busy && r_cnt == '0, r_done && !r_busy, "last step did not finish the operation")
    `PLI_ASSERT_IMPL(a_quot_bound, i_clk, i_rst_n, r_done && r_op == plin_pkg::ALU_DIV && r_q[FRAC_BITS], r_q[FRAC_BITS-1:0] == '0, "fraction above one")

endmodule

`default_nettype wire
